FILE: src/mm3_pkg.sv
// Package for the MurmurHash3 x64_128 stream hash: types, constants, helpers.
`timescale 1ns / 1ps
`default_nettype none
package mm3_pkg;
	localparam logic [63:0] MUL_A  = 64'h87c37b91114253d5;
	localparam logic [63:0] MUL_B  = 64'h4cf5ad432745937f;
	localparam logic [63:0] ADD_A  = 64'h0000000052dce729;
	localparam logic [63:0] ADD_B  = 64'h0000000038495ab5;
	localparam logic [63:0] FMIX_A = 64'hff51afd7ed558ccd;
	localparam logic [63:0] FMIX_B = 64'hc4ceb9fe1a85ec53;
	localparam int QDEPTH = 2;

	typedef struct packed {
		logic [63:0] word_low;
		logic [63:0] word_high;
		logic [4:0]  byte_count;
		logic        last;
	} in_item_t;

	typedef struct packed {
		logic [63:0] hash_low;
		logic [63:0] hash_high;
	} out_item_t;

	// Classified command passed from front to back.
	typedef struct packed {
		logic [63:0] k1;
		logic [63:0] k2;
		logic        full;
		logic        last;
		logic        first;
		logic [4:0]  nbytes;
		logic [63:0] seed;
	} cmd_t;

	function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] r);
		rotl64 = (v << r) | (v >> (7'd64 - {1'b0, r}));
	endfunction

	function automatic logic [63:0] byte_mask(input logic [4:0] n);
		byte_mask = (n >= 5'd8) ? '1 : ((64'd1 << {n[2:0], 3'b000}) - 64'd1);
	endfunction
endpackage
`default_nettype wire

FILE: src/mm3_front.sv
// Front end: accepts chunks, masks tails and queues commands for the back end.
`timescale 1ns / 1ps
`default_nettype none
module mm3_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 valid,
	output logic                stall,
	input  mm3_pkg::in_item_t   din,
	input  wire  [63:0]         seed,
	output logic                cmd_valid,
	input  wire                 cmd_take,
	output mm3_pkg::cmd_t       cmd
);
	import mm3_pkg::*;

	cmd_t        q_mem_q [QDEPTH];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	logic        open_q;
	cmd_t        c;
	logic        acc, is_full;

	// Classify the incoming chunk.
	always_comb begin
		is_full = !din.last || din.byte_count >= 5'd16;
		c.full = is_full;
		c.last = din.last;
		c.first = !open_q;
		c.seed = seed;
		c.nbytes = is_full ? 5'd16 : din.byte_count;
		c.k1 = is_full ? din.word_low : (din.word_low & byte_mask(din.byte_count));
		c.k2 = is_full ? din.word_high :
			(din.byte_count > 5'd8 ? (din.word_high & byte_mask(din.byte_count - 5'd8)) : '0);
	end

	assign stall = (cnt_q == 2'(QDEPTH));
	assign acc = valid && !stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_mem_q[rp_q];

	// Write the queue.
	always_ff @(posedge clk) begin
		if (acc) q_mem_q[wp_q] <= c;
	end

	// Advance pointers and track message state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0; open_q <= 1'b0;
		end else begin
			if (acc) begin
				wp_q <= ~wp_q;
				open_q <= !din.last;
			end
			if (cmd_take && cmd_valid) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(acc) - 2'(cmd_take && cmd_valid);
		end
	end

`ifndef ASSERT_OFF
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(QDEPTH))
		else $error("queue overflow");
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> wp_q == rp_q) else $error("pointer mismatch");
	a_take: assert property (@(posedge clk) disable iff (!arst_n) cmd_take |-> cmd_valid)
		else $error("take from empty queue");
`endif
endmodule
`default_nettype wire

FILE: src/mm3_back.sv
// Back end: sequencer around one shared 32x32 multiplier that mixes and finalizes.
`timescale 1ns / 1ps
`default_nettype none
module mm3_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cmd_valid,
	output logic                cmd_take,
	input  mm3_pkg::cmd_t       cmd,
	output logic                valid,
	input  wire                 stall,
	output mm3_pkg::out_item_t  dout
);
	import mm3_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001, S_K1A = 9'b000000010, S_K1B = 9'b000000100,
		S_K2A  = 9'b000001000, S_K2B = 9'b000010000, S_MIX = 9'b000100000,
		S_F1   = 9'b001000000, S_F2  = 9'b010000000, S_OUT = 9'b100000000
	} st_t;

	st_t         st_q;
	cmd_t        c_q;
	logic [63:0] h1_q, h2_q, len_q, k_q;
	logic [63:0] ma, mb, mp;
	logic [2:0]  fstep_q;
	logic        lane_q;
	logic [63:0] fx, h1x, h1n, h2x, h2n, a1, a2;
	out_item_t   out_q;
	logic        ov_q;
	logic [1:0]  mph_q;
	logic [63:0] macc_q, mprod;
	logic [31:0] mx, my;
	logic        mul_st, mul_done;

	// Shared multiplier operand select.
	always_comb begin
		ma = k_q; mb = MUL_A;
		case (st_q)
			S_K1A: begin ma = c_q.k1; mb = MUL_A; end
			S_K1B: begin ma = rotl64(k_q, 6'd31); mb = MUL_B; end
			S_K2A: begin ma = c_q.k2; mb = MUL_B; end
			S_K2B: begin ma = rotl64(k_q, 6'd33); mb = MUL_A; end
			S_F1:  begin ma = fx; mb = fstep_q[0] ? FMIX_B : FMIX_A; end
			default: begin ma = k_q; mb = MUL_A; end
		endcase
	end
	assign fx = k_q ^ (k_q >> 33);

	// Build the low 64 bits of ma * mb from three 32x32 partial products.
	always_comb begin
		case (mph_q)
			2'd0: begin mx = ma[31:0]; my = mb[31:0]; end
			2'd1: begin mx = ma[31:0]; my = mb[63:32]; end
			default: begin mx = ma[63:32]; my = mb[31:0]; end
		endcase
	end
	assign mprod = 64'(mx) * 64'(my);
	assign mp = macc_q + {mprod[31:0], 32'd0};
	assign mul_st = st_q inside {S_K1A, S_K1B, S_K2A, S_K2B, S_F1};
	assign mul_done = mul_st && (mph_q == 2'd2);

	// Step the multiply phase and accumulate partial products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mph_q <= 2'd0; macc_q <= '0;
		end else begin
			if (mul_st && !mul_done) mph_q <= mph_q + 2'd1;
			else mph_q <= 2'd0;
			if (mph_q == 2'd0) macc_q <= mprod;
			else macc_q <= mp;
		end
	end

	// Block-mix lane arithmetic on the key results.
	always_comb begin
		h1x = h1_q ^ k_q;
		a1 = rotl64(h1x, 6'd27) + h2_q;
		h1n = {a1[61:0], 2'b00} + a1 + ADD_A;
		h2x = h2_q ^ k_q;
		a2 = rotl64(h2x, 6'd31) + h1_q;
		h2n = {a2[61:0], 2'b00} + a2 + ADD_B;
	end

	assign cmd_take = (st_q == S_IDLE) && cmd_valid;
	assign valid = ov_q;
	assign dout = out_q;

	// Sequence one command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; ov_q <= 1'b0; fstep_q <= '0; lane_q <= 1'b0;
			h1_q <= '0; h2_q <= '0; len_q <= '0;
			c_q <= '0; k_q <= '0; out_q <= '0;
		end else begin
			if (ov_q && !stall) ov_q <= 1'b0;
			case (st_q)
				S_IDLE: if (cmd_valid) begin
					c_q <= cmd;
					if (cmd.first) begin
						h1_q <= cmd.seed; h2_q <= cmd.seed; len_q <= '0;
					end
					st_q <= S_K1A;
				end
				S_K1A: if (mul_done) begin k_q <= mp; st_q <= S_K1B; end
				S_K1B: if (mul_done) begin
					if (c_q.full) begin
						k_q <= mp; st_q <= S_MIX; lane_q <= 1'b0;
					end else begin
						h1_q <= h1_q ^ mp; st_q <= S_K2A;
					end
				end
				S_K2A: if (mul_done) begin k_q <= mp; st_q <= S_K2B; end
				S_K2B: if (mul_done) begin
					len_q <= len_q + 64'(c_q.nbytes);
					if (c_q.full) begin
						k_q <= mp; st_q <= S_MIX; lane_q <= 1'b1;
					end else begin
						h2_q <= h2_q ^ mp; lane_q <= 1'b1; st_q <= S_F2;
					end
				end
				S_MIX: begin
					if (!lane_q) begin
						h1_q <= h1n; st_q <= S_K2A;
					end else begin
						h2_q <= h2n;
						st_q <= c_q.last ? S_F2 : S_IDLE;
					end
				end
				S_F2: begin
					// Fold the length in, then start fmix on lane one.
					h1_q <= (h1_q ^ len_q) + (h2_q ^ len_q);
					h2_q <= (h2_q ^ len_q) + (h1_q ^ len_q) + (h2_q ^ len_q);
					k_q <= (h1_q ^ len_q) + (h2_q ^ len_q);
					fstep_q <= 3'd0; st_q <= S_F1;
				end
				S_F1: if (mul_done) begin
					// Two multiply rounds per lane, fstep[1] selects lane.
					if (fstep_q[0] == 1'b0) begin
						k_q <= mp; fstep_q <= fstep_q + 3'd1;
					end else if (fstep_q[1] == 1'b0) begin
						h1_q <= mp ^ (mp >> 33); k_q <= h2_q; fstep_q <= 3'd2;
					end else begin
						h2_q <= mp ^ (mp >> 33); st_q <= S_OUT;
					end
				end
				S_OUT: if (!ov_q || !stall) begin
					out_q.hash_low <= h1_q + h2_q;
					out_q.hash_high <= h2_q + h1_q + h2_q;
					ov_q <= 1'b1; st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && stall) |=> ov_q) else $error("result dropped");
	a_oh: assert property (@(posedge clk) disable iff (!arst_n) $onehot(st_q))
		else $error("state not one-hot");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |=> st_q == S_K1A) else $error("command not started");
	a_mph: assert property (@(posedge clk) disable iff (!arst_n) mph_q != 2'd3)
		else $error("multiply phase out of range");
`endif
endmodule
`default_nettype wire

FILE: src/murmur3_128_stream_hash.sv
// Top level of the MurmurHash3 x64_128 stream hash.
// Hashes 16-byte chunks with a 64-bit seed; the result appears after the last
// chunk. Every 64-bit multiply is built from three partial products on one shared
// 32x32 multiplier, and the multiplies run one after another. A full chunk passes
// through the back end as taking the command, four multiplies and two lane
// updates; a last chunk adds the length fold, four fmix multiplies and the output
// step, and a partial last chunk skips the lane updates. A result held by the
// receiver keeps the back end waiting. A two-entry queue lets the front accept
// chunks while the back end is busy. The seed applies from the next message.
`timescale 1ns / 1ps
`default_nettype none
module murmur3_128_stream_hash (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  mm3_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  wire                 out_stall,
	output mm3_pkg::out_item_t  out_data,
	input  wire                 cfg_we,
	input  wire  [63:0]         cfg_wdata
);
	import mm3_pkg::*;

	logic [63:0] seed_q;
	logic        cv, ct;
	cmd_t        cm;

	// Hold the seed register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seed_q <= '0;
		else if (cfg_we) seed_q <= cfg_wdata;
	end

	mm3_front u_front (.clk, .arst_n, .valid(in_valid), .stall(in_stall), .din(in_data),
		.seed(seed_q), .cmd_valid(cv), .cmd_take(ct), .cmd(cm));
	mm3_back u_back (.clk, .arst_n, .cmd_valid(cv), .cmd_take(ct), .cmd(cm),
		.valid(out_valid), .stall(out_stall), .dout(out_data));
endmodule
`default_nettype wire
